FILE: hw/rtl/software_timer_bank_macros.svh
// Assertion helpers for the checker file of the timer bank.
`ifndef SOFTWARE_TIMER_BANK_MACROS_SVH
`define SOFTWARE_TIMER_BANK_MACROS_SVH

// Generic form with an explicit clock and active-low reset.
`define STB_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Short form on the usual clock and reset names.
`define STB_ASSERT(lbl, prop, msg) `STB_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: hw/rtl/stb_pkg.sv
package stb_pkg;

  localparam int unsigned US_PER_MS = 1000;
  localparam int unsigned NOW_W     = 48;
  localparam int unsigned PERIOD_W  = 26;
  localparam int unsigned EXP_MS_W  = 39;

  typedef enum logic [1:0] {
    MODE_UNUSED  = 2'd0,
    MODE_CREATED = 2'd1,
    MODE_RUNNING = 2'd2,
    MODE_STOPPED = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_CREATE = 3'd1,
    CMD_START  = 3'd2,
    CMD_STOP   = 3'd3,
    CMD_SETP   = 3'd4,
    CMD_QUERY  = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [2:0]       slot;
    logic [15:0]      period_ms;
    logic             oneshot;
    logic [NOW_W-1:0] now_us;
  } in_req_t;

  typedef struct packed {
    logic                kind;
    logic [2:0]          slot_out;
    logic                status;
    logic                is_running;
    logic [EXP_MS_W-1:0] expiry_ms;
    logic                last;
  } out_rsp_t;

  // Control broadcast from the sequencer to every slot cell.
  typedef struct packed {
    logic                launch;
    logic                adv;
    logic                apply;
    cmd_e                op;
    logic [PERIOD_W-1:0] period_us;
    logic                oneshot;
  } cell_ctl_t;

  // True when the command may act on a slot in the given mode.
  function automatic logic cmd_ok(cmd_e op, mode_e mode);
    logic ok;
    case (op)
      CMD_CREATE: ok = 1'b1;
      CMD_START:  ok = (mode != MODE_RUNNING) && (mode != MODE_UNUSED);
      CMD_STOP:   ok = (mode == MODE_RUNNING);
      CMD_SETP:   ok = (mode == MODE_CREATED) || (mode == MODE_RUNNING);
      CMD_QUERY:  ok = 1'b1;
      default:    ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

FILE: hw/rtl/stb_cell.sv
module stb_cell import stb_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctl_t             ctl_i,
  input  logic                  sel_i,
  input  logic                  tok_i,
  input  logic [TIME_WIDTH-1:0] now_i,
  output logic                  tok_o,
  output logic                  hit_o,
  output mode_e                 mode_o,
  output logic [TIME_WIDTH-1:0] expiry_o
);

  mode_e                 mode_q;
  logic                  oneshot_q;
  logic [PERIOD_W-1:0]   period_q;
  logic [TIME_WIDTH-1:0] expiry_q;
  logic                  tok_q;
  logic                  due;
  logic                  apply;
  logic [TIME_WIDTH-1:0] reload;

  assign due    = (mode_q == MODE_RUNNING) && (now_i >= expiry_q);
  assign hit_o  = tok_q && due;
  assign apply  = ctl_i.apply && sel_i && cmd_ok(ctl_i.op, mode_q);
  assign reload = now_i + TIME_WIDTH'(period_q);

  assign tok_o    = tok_q;
  assign mode_o   = mode_q;
  assign expiry_o = expiry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q     <= 1'b0;
      mode_q    <= MODE_UNUSED;
      oneshot_q <= 1'b0;
      period_q  <= '0;
      expiry_q  <= '0;
    end else begin
      if (ctl_i.adv) begin
        tok_q <= tok_i;
      end
      if (ctl_i.adv && hit_o) begin
        if (oneshot_q) begin
          mode_q <= MODE_STOPPED;
        end else begin
          expiry_q <= reload;
        end
      end else if (apply) begin
        case (ctl_i.op)
          CMD_CREATE: begin
            period_q  <= ctl_i.period_us;
            oneshot_q <= ctl_i.oneshot;
            mode_q    <= MODE_CREATED;
          end
          CMD_START: begin
            expiry_q <= reload;
            mode_q   <= MODE_RUNNING;
          end
          CMD_STOP: begin
            mode_q <= MODE_STOPPED;
          end
          CMD_SETP: begin
            period_q <= ctl_i.period_us;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

FILE: hw/rtl/stb_div1000.sv
module stb_div1000 import stb_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [TIME_WIDTH-1:0] dividend_i,
  output logic                  done_o,
  output logic [TIME_WIDTH-1:0] quot_o
);

  localparam int unsigned BitsPerStep = 8;
  localparam int unsigned Steps = (TIME_WIDTH + BitsPerStep - 1) / BitsPerStep;
  localparam int unsigned PadW  = Steps * BitsPerStep;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  // The word holds the remaining dividend bits at the top and collects the
  // quotient bits at the bottom, as in a classic restoring divider.
  logic [PadW-1:0] word_q, word_d;
  logic [9:0]      rem_q, rem_d;
  logic [10:0]     trial;
  logic [CntW-1:0] cnt_q;
  logic            run_q;
  logic            done_q;

  always_comb begin
    rem_d  = rem_q;
    word_d = word_q;
    trial  = '0;
    for (int k = 0; k < BitsPerStep; k++) begin
      trial  = {rem_d, word_d[PadW-1]};
      word_d = {word_d[PadW-2:0], 1'b0};
      if (trial >= 11'(US_PER_MS)) begin
        rem_d     = 10'(trial - 11'(US_PER_MS));
        word_d[0] = 1'b1;
      end else begin
        rem_d = trial[9:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(Steps);
      end else if (run_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      word_q <= PadW'(dividend_i);
      rem_q  <= '0;
    end else if (run_q) begin
      word_q <= word_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = word_q[TIME_WIDTH-1:0];

endmodule

FILE: hw/rtl/software_timer_bank.sv
// Channel   Handshake                  Payload
// in        in_valid_i / in_ready_o    in_req_i  (in_req_t)
// out       out_valid_o / out_ready_i  out_rsp_o (out_rsp_t)
// config    cfg_we_i                   cfg_wdata_i (service enable)
//
// One request is handled at a time; in_ready_o is high only while idle.
// A command waits on the divide by 1000 that turns the expiry into
// milliseconds, eight bits per cycle. A tick walks a token down the row of
// slot cells, one cell per cycle while no expired slot is being sent; each
// expired slot is held until the walk finds the next one or reaches the end,
// and is then sent. Reset clears every slot to unused and disables the
// service; a stalled output holds the walk until the result is taken.
module software_timer_bank import stb_pkg::*; #(
  parameter int unsigned NUM_SLOTS  = 8,
  parameter int unsigned TIME_WIDTH = 48
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_rsp_t out_rsp_o
);

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_WALK,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e                state_q, back_q;
  logic                  en_q;
  logic [IdxW-1:0]       idx_q, sel_q, pend_idx_q;
  logic                  pend_q, last_q, kind_q, status_q, started_q;
  logic                  op_valid_q, oneshot_q;
  cmd_e                  op_q;
  logic [PERIOD_W-1:0]   period_q;
  logic [TIME_WIDTH-1:0] now_q;
  out_rsp_t              out_q;
  logic                  out_valid_q;

  logic                      in_acc, is_tick, flush_now, at_end, any_hit, slot_ok;
  logic                      div_start, div_done;
  logic [IdxW+2:0]           slot_ext, sel_ext;
  logic [TIME_WIDTH+47:0]    now_ext;
  logic [TIME_WIDTH-1:0]     quot;
  logic [TIME_WIDTH+38:0]    quot_ext;
  logic [PERIOD_W-1:0]       period_calc;
  cell_ctl_t                 ctl;
  logic [NUM_SLOTS:0]        tok_ext;
  logic [NUM_SLOTS-1:0]      tok_out, hit_vec, sel_vec;
  mode_e                     cell_mode [NUM_SLOTS];
  logic [TIME_WIDTH-1:0]     cell_exp  [NUM_SLOTS];
  mode_e                     rd_mode;
  logic [TIME_WIDTH-1:0]     rd_exp;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_tick    = (in_req_i.cmd == CMD_TICK);

  assign slot_ext    = {IdxW'(0), in_req_i.slot};
  assign slot_ok     = slot_ext < (IdxW + 3)'(NUM_SLOTS);
  assign sel_ext     = {3'b000, sel_q};
  assign now_ext     = {TIME_WIDTH'(0), in_req_i.now_us};
  assign period_calc = {10'b0, in_req_i.period_ms} * PERIOD_W'(US_PER_MS);
  assign quot_ext    = {39'b0, quot};

  assign any_hit   = |hit_vec;
  assign at_end    = (idx_q == IdxW'(NUM_SLOTS - 1));
  // A second expired slot has to wait until the held one has been sent.
  assign flush_now = (state_q == ST_WALK) && any_hit && pend_q;
  assign div_start = (state_q == ST_DIV) && !started_q;

  assign ctl.launch    = in_acc && is_tick && en_q;
  assign ctl.adv       = ctl.launch || ((state_q == ST_WALK) && !flush_now);
  assign ctl.apply     = (state_q == ST_CMD) && op_valid_q;
  assign ctl.op        = op_q;
  assign ctl.period_us = period_q;
  assign ctl.oneshot   = oneshot_q;

  assign tok_ext = {tok_out, ctl.launch};
  assign rd_mode = cell_mode[sel_q];
  assign rd_exp  = cell_exp[sel_q];

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cells
    assign sel_vec[i] = (sel_q == IdxW'(i));

    stb_cell #(
      .TIME_WIDTH(TIME_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .sel_i   (sel_vec[i]),
      .tok_i   (tok_ext[i]),
      .now_i   (now_q),
      .tok_o   (tok_out[i]),
      .hit_o   (hit_vec[i]),
      .mode_o  (cell_mode[i]),
      .expiry_o(cell_exp[i])
    );
  end

  stb_div1000 #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(rd_exp),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      back_q      <= ST_IDLE;
      en_q        <= 1'b0;
      idx_q       <= '0;
      sel_q       <= '0;
      pend_idx_q  <= '0;
      pend_q      <= 1'b0;
      last_q      <= 1'b0;
      kind_q      <= 1'b0;
      status_q    <= 1'b0;
      started_q   <= 1'b0;
      op_valid_q  <= 1'b0;
      op_q        <= CMD_QUERY;
      oneshot_q   <= 1'b0;
      period_q    <= '0;
      now_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            now_q <= now_ext[TIME_WIDTH-1:0];
            if (is_tick) begin
              if (en_q) begin
                idx_q    <= '0;
                pend_q   <= 1'b0;
                kind_q   <= 1'b1;
                status_q <= 1'b0;
                state_q  <= ST_WALK;
              end
            end else begin
              kind_q    <= 1'b0;
              last_q    <= 1'b1;
              back_q    <= ST_IDLE;
              sel_q     <= slot_ext[IdxW-1:0];
              period_q  <= period_calc;
              oneshot_q <= in_req_i.oneshot;
              if (in_req_i.cmd <= CMD_QUERY) begin
                op_valid_q <= 1'b1;
                op_q       <= cmd_e'(in_req_i.cmd);
              end else begin
                op_valid_q <= 1'b0;
                op_q       <= CMD_QUERY;
              end
              if (!slot_ok) begin
                out_q.kind       <= 1'b0;
                out_q.slot_out   <= in_req_i.slot;
                out_q.status     <= 1'b1;
                out_q.is_running <= 1'b0;
                out_q.expiry_ms  <= '0;
                out_q.last       <= 1'b1;
                out_valid_q      <= 1'b1;
                state_q          <= ST_OUT;
              end else begin
                state_q <= ST_CMD;
              end
            end
          end
        end
        ST_CMD: begin
          status_q  <= !op_valid_q || !cmd_ok(op_q, rd_mode);
          started_q <= 1'b0;
          state_q   <= ST_DIV;
        end
        ST_WALK: begin
          if (flush_now) begin
            sel_q     <= pend_idx_q;
            last_q    <= 1'b0;
            back_q    <= ST_WALK;
            pend_q    <= 1'b0;
            started_q <= 1'b0;
            state_q   <= ST_DIV;
          end else begin
            idx_q <= idx_q + IdxW'(1);
            if (any_hit) begin
              pend_q     <= 1'b1;
              pend_idx_q <= idx_q;
            end
            if (at_end) begin
              if (any_hit || pend_q) begin
                sel_q     <= any_hit ? idx_q : pend_idx_q;
                last_q    <= 1'b1;
                back_q    <= ST_IDLE;
                pend_q    <= 1'b0;
                started_q <= 1'b0;
                state_q   <= ST_DIV;
              end else begin
                state_q <= ST_IDLE;
              end
            end
          end
        end
        ST_DIV: begin
          if (!started_q) begin
            started_q <= 1'b1;
          end else if (div_done) begin
            out_q.kind       <= kind_q;
            out_q.slot_out   <= sel_ext[2:0];
            out_q.status     <= status_q;
            out_q.is_running <= (rd_mode == MODE_RUNNING);
            out_q.expiry_ms  <= quot_ext[EXP_MS_W-1:0];
            out_q.last       <= last_q;
            out_valid_q      <= 1'b1;
            state_q          <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= back_q;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

FILE: hw/rtl/stb_checker.sv
`include "software_timer_bank_macros.svh"

module stb_checker import stb_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input out_rsp_t out_rsp_o
);

  // Requests are taken only while no result is on offer.
  `STB_ASSERT(a_ready_excl, !(in_ready_o && out_valid_o), "ready while result pending")

  // An offered result stays until it is taken.
  `STB_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")

  // Expiry events never carry an error status.
  `STB_ASSERT(a_event_ok, out_valid_o && out_rsp_o.kind |-> !out_rsp_o.status, "event with error")

  // Once the final result of a request is taken, the bank is free again.
  `STB_ASSERT(a_last_free, out_valid_o && out_ready_i && out_rsp_o.last |=> in_ready_o, "not idle after last")

endmodule

bind software_timer_bank stb_checker u_stb_checker (.*);

FILE: dv/software_timer_bank_tb.sv
module software_timer_bank_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stb_pkg::*;

  localparam int unsigned NUM_SLOTS     = 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 120;

  // Command codes that the package leaves undefined.
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  localparam logic [NOW_W-1:0] NOW_MAX = {NOW_W{1'b1}};

  logic     clk_i;
  logic     rst_n     = 1'b0;
  logic     cfg_we    = 1'b0;
  logic     cfg_wdata = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_rsp;

  // Mirror of the bank's slot state.
  mode_e               slot_mode [NUM_SLOTS];
  logic                slot_one  [NUM_SLOTS];
  logic [PERIOD_W-1:0] slot_per  [NUM_SLOTS];
  logic [NOW_W-1:0]    slot_exp  [NUM_SLOTS];
  logic                service_en;

  out_rsp_t         timer_rsps [$];
  int unsigned      mismatches = 0;
  int unsigned      cycle_cnt  = 0;
  int unsigned      ready_hold = 0;
  bit               quiet      = 1'b0;
  logic [NOW_W-1:0] now_cursor = 48'd10000;

  software_timer_bank dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic out_rsp_t slot_rsp(logic kind, logic [2:0] s, logic status, logic last);
    out_rsp_t         o;
    logic [NOW_W-1:0] q;
    q            = slot_exp[s] / US_PER_MS;
    o.kind       = kind;
    o.slot_out   = s;
    o.status     = status;
    o.is_running = (slot_mode[s] == MODE_RUNNING);
    o.expiry_ms  = q[EXP_MS_W-1:0];
    o.last       = last;
    return o;
  endfunction

  // Updates the mirrored state for one request and queues the results it causes.
  function automatic void apply_timer_request(in_req_t r);
    logic [31:0]         prod;
    logic [PERIOD_W-1:0] per;
    logic                status;
    int                  s;
    out_rsp_t            fired [$];
    prod   = r.period_ms * US_PER_MS;
    per    = prod[PERIOD_W-1:0];
    s      = r.slot;
    status = 1'b0;
    if (r.cmd == CMD_TICK) begin
      if (!service_en) return;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_mode[i] == MODE_RUNNING && r.now_us >= slot_exp[i]) begin
          if (slot_one[i]) slot_mode[i] = MODE_STOPPED;
          else slot_exp[i] = r.now_us + slot_per[i];
          fired.push_back(slot_rsp(1'b1, i[2:0], 1'b0, 1'b0));
        end
      end
      if (fired.size() != 0) fired[fired.size()-1].last = 1'b1;
      foreach (fired[k]) timer_rsps.push_back(fired[k]);
      return;
    end
    case (r.cmd)
      CMD_CREATE: begin
        slot_per[s]  = per;
        slot_one[s]  = r.oneshot;
        slot_mode[s] = MODE_CREATED;
      end
      CMD_START: begin
        if (slot_mode[s] == MODE_RUNNING || slot_mode[s] == MODE_UNUSED) begin
          status = 1'b1;
        end else begin
          slot_exp[s]  = r.now_us + slot_per[s];
          slot_mode[s] = MODE_RUNNING;
        end
      end
      CMD_STOP: begin
        if (slot_mode[s] != MODE_RUNNING) status = 1'b1;
        else slot_mode[s] = MODE_STOPPED;
      end
      CMD_SETP: begin
        if (slot_mode[s] != MODE_CREATED && slot_mode[s] != MODE_RUNNING) status = 1'b1;
        else slot_per[s] = per;
      end
      CMD_QUERY: ;
      default: status = 1'b1;
    endcase
    timer_rsps.push_back(slot_rsp(1'b0, r.slot, status, 1'b1));
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_cnt, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(out_rsp_t got);
    out_rsp_t want;
    if (timer_rsps.size() == 0) begin
      report_mismatch("result with none awaited", got, 0);
      return;
    end
    want = timer_rsps.pop_front();
    if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
    if (got.slot_out !== want.slot_out) report_mismatch("slot_out", got.slot_out, want.slot_out);
    if (got.status !== want.status) report_mismatch("status", got.status, want.status);
    if (got.is_running !== want.is_running)
      report_mismatch("is_running", got.is_running, want.is_running);
    if (got.expiry_ms !== want.expiry_ms)
      report_mismatch("expiry_ms", got.expiry_ms, want.expiry_ms);
    if (got.last !== want.last) report_mismatch("last", got.last, want.last);
  endtask

  // Results are taken at the edge using the ready level held before it; stalls
  // come in bursts except in the quiet stretch at the end.
  always @(posedge clk_i) begin
    if (rst_n && out_valid && out_ready) check_result(out_rsp);
    if (ready_hold > 0) ready_hold--;
    else if (!quiet && $urandom_range(0, 7) == 0) ready_hold = $urandom_range(1, 11);
    out_ready <= (ready_hold == 0);
  end

  function automatic in_req_t make_req(logic [2:0] c, logic [2:0] s, logic [15:0] pms,
                                       logic one, logic [NOW_W-1:0] t);
    in_req_t r;
    r.cmd       = c;
    r.slot      = s;
    r.period_ms = pms;
    r.oneshot   = one;
    r.now_us    = t;
    return r;
  endfunction

  // Valid is left high on return so that a following request can follow
  // without a gap; release_in lowers it.
  task automatic send_req(in_req_t r);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk_i); while (!in_ready);
    apply_timer_request(r);
  endtask

  task automatic release_in();
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (timer_rsps.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_service(logic en);
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk_i);
    cfg_we     <= 1'b0;
    service_en  = en;
  endtask

  // A tick that fires nothing may still be walking the slots once the queue
  // is empty, hence the settling pause before the register is touched.
  task automatic settle_then_set(logic en);
    release_in();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    set_service(en);
  endtask

  task automatic test_command_rules();
    send_req(make_req(CMD_START, 3'd0, 16'd1, 1'b0, 48'd0));
    send_req(make_req(CMD_STOP, 3'd0, 16'd1, 1'b0, 48'd0));
    send_req(make_req(CMD_SETP, 3'd0, 16'd1, 1'b0, 48'd0));
    send_req(make_req(CMD_QUERY, 3'd0, 16'd0, 1'b0, 48'd0));
    send_req(make_req(CMD_RSVD6, 3'd1, 16'd5, 1'b1, NOW_MAX));
    send_req(make_req(CMD_RSVD7, 3'd2, 16'hFFFF, 1'b0, 48'd0));
    send_req(make_req(CMD_CREATE, 3'd5, 16'hFFFF, 1'b1, 48'd0));
    send_req(make_req(CMD_SETP, 3'd5, 16'hFFFF, 1'b0, 48'd0));
    // Start at the very top of the time range so that the expiry wraps.
    send_req(make_req(CMD_START, 3'd5, 16'd0, 1'b0, NOW_MAX));
    send_req(make_req(CMD_START, 3'd5, 16'd0, 1'b0, 48'd0));
    send_req(make_req(CMD_TICK, 3'd7, 16'hFFFF, 1'b1, NOW_MAX));
    send_req(make_req(CMD_STOP, 3'd5, 16'd0, 1'b0, 48'd0));
    send_req(make_req(CMD_STOP, 3'd5, 16'd0, 1'b0, 48'd0));
    send_req(make_req(CMD_SETP, 3'd5, 16'd3, 1'b0, 48'd0));
    send_req(make_req(CMD_START, 3'd5, 16'd0, 1'b0, 48'd0));
    send_req(make_req(CMD_QUERY, 3'd5, 16'd0, 1'b0, 48'd0));
  endtask

  // Slot i gets a period of i ms, odd slots one-shot; the tick at 7000 us finds
  // all eight due at once.
  task automatic test_expiry_walk();
    for (int i = 0; i < NUM_SLOTS; i++)
      send_req(make_req(CMD_CREATE, i[2:0], 16'(i), i[0], 48'd0));
    for (int i = 0; i < NUM_SLOTS; i++)
      send_req(make_req(CMD_START, i[2:0], 16'd0, 1'b0, 48'd0));
    send_req(make_req(CMD_TICK, 3'd0, 16'd0, 1'b0, 48'd0));
    send_req(make_req(CMD_TICK, 3'd0, 16'd0, 1'b0, 48'd7000));
    send_req(make_req(CMD_TICK, 3'd0, 16'd0, 1'b0, 48'd7001));
  endtask

  task automatic test_random_traffic(int count);
    int               pick;
    logic [2:0]       c;
    logic [15:0]      pms;
    logic [NOW_W-1:0] t;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) c = CMD_TICK;
      else if (pick < 57) c = CMD_CREATE;
      else if (pick < 72) c = CMD_START;
      else if (pick < 80) c = CMD_STOP;
      else if (pick < 88) c = CMD_SETP;
      else if (pick < 95) c = CMD_QUERY;
      else if (pick < 98) c = CMD_RSVD6;
      else c = CMD_RSVD7;
      pick = $urandom_range(0, 99);
      if (pick < 85) pms = 16'($urandom_range(0, 12));
      else if (pick < 95) pms = 16'($urandom);
      else pms = 16'hFFFF;
      // Mostly a steadily advancing clock, now and then an arbitrary time.
      if ($urandom_range(0, 99) < 85) begin
        now_cursor = now_cursor + 48'($urandom_range(0, 4000));
        t          = now_cursor;
      end else begin
        t = {16'($urandom), 32'($urandom)};
      end
      send_req(make_req(c, 3'($urandom_range(0, 7)), pms, 1'($urandom_range(0, 1)), t));
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_mode[i] = MODE_UNUSED;
      slot_one[i]  = 1'b0;
      slot_per[i]  = '0;
      slot_exp[i]  = '0;
    end
    service_en = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    set_service(1'b0);
    test_command_rules();
    settle_then_set(1'b1);
    test_expiry_walk();
    test_random_traffic(45);
    settle_then_set(1'b0);
    test_random_traffic(20);
    settle_then_set(1'b1);
    quiet = 1'b1;
    test_random_traffic(30);
    release_in();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
